>>> design/i2ccd_pkg.sv
// Shared types and constants for the serial clock divider search block.
// Holds the divider table, field widths and sequencer state codes.
// No dependencies.
package i2ccd_pkg;

  localparam int CLK_W  = 28;
  localparam int TGT_W  = 23;
  localparam int DIVR_W = 12;
  localparam int IDX_W  = 6;
  localparam int ERR_W  = 16;
  localparam int LTO_W  = 11;
  localparam int CNT_W  = 5;

  localparam logic [ERR_W-1:0] ERR_START       = 16'hFFFF;
  localparam logic [CLK_W-1:0] BUS_CLOCK_RESET = 28'd48000000;
  localparam logic [CNT_W-1:0] DIV_LAST_STEP   = 5'(CLK_W - 1);
  localparam logic [IDX_W-1:0] IDX_LAST        = 6'd63;

  localparam logic [1:0] MULT_X1 = 2'd0;
  localparam logic [1:0] MULT_X2 = 2'd1;
  localparam logic [1:0] MULT_X4 = 2'd2;

  localparam logic [DIVR_W-1:0] DIV_ROM [64] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
    12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
    12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
    12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
    12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
    12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
    12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
    12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
  };

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  function automatic logic [DIVR_W-1:0] div_rom(input logic [IDX_W-1:0] idx);
    return DIV_ROM[idx];
  endfunction

endpackage

>>> design/i2c_clock_divider_search.sv
// Top level of the serial clock divider search block.
// Holds the APB register, the search sequencer and the shared divider.
// Depends on i2ccd_pkg.

// A request is a transfer of target_hz; the block walks all 64 divider table
// entries and returns one result transfer with the first entry that comes
// closest to the request from below. For each entry the shared
// one-bit-per-cycle restoring divider forms bus clock over divider, and
// S_EVAL then applies the prescale and compares against the best so far.
// in_ready stays low from acceptance until the result is moved to the
// output, also while S_FINISH waits for an earlier result. The next request
// can be taken while the previous result still waits on the output.
module i2c_clock_divider_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [i2ccd_pkg::TGT_W-1:0] target_hz,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [i2ccd_pkg::IDX_W-1:0] divider_index,
  output logic [1:0]                  multiplier_code,
  output logic [i2ccd_pkg::TGT_W-1:0] achieved_hz,
  output logic [i2ccd_pkg::LTO_W-1:0] low_timeout
);
  import i2ccd_pkg::*;

  state_t              state;
  logic [CLK_W-1:0]    bus_clock_hz;
  logic [TGT_W-1:0]    tgt;
  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    cnt;
  logic [CLK_W-1:0]    quo;
  logic [DIVR_W-1:0]   rem;
  logic [ERR_W-1:0]    best_err;
  logic [IDX_W-1:0]    best_idx;
  logic [TGT_W-1:0]    best_rate;
  logic [1:0]          best_mult;
  logic                best_found;

  logic [DIVR_W-1:0]   divisor;
  logic [DIVR_W:0]     trial;
  logic [DIVR_W:0]     diff;
  logic                q_bit;
  logic [CLK_W-1:0]    tgt_ext;
  logic [CLK_W-1:0]    q1;
  logic [CLK_W-1:0]    q2;
  logic [CLK_W-1:0]    rate_sel;
  logic [1:0]          mult_sel;
  logic                rate_ok;
  logic [TGT_W-1:0]    err;
  logic                better;
  logic [DIVR_W-1:0]   best_div;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {{(32-CLK_W){1'b0}}, bus_clock_hz} : 32'd0;
  assign in_ready = (state == S_IDLE);

  assign divisor = div_rom(idx);
  assign trial   = {rem, quo[CLK_W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign q_bit   = (trial >= {1'b0, divisor});

  assign tgt_ext = {{(CLK_W-TGT_W){1'b0}}, tgt};
  assign q1      = quo >> 1;
  assign q2      = quo >> 2;

  always_comb begin
    rate_ok  = 1'b1;
    rate_sel = quo;
    mult_sel = MULT_X1;
    priority if (quo <= tgt_ext) begin
      rate_sel = quo;
      mult_sel = MULT_X1;
    end else if (q1 <= tgt_ext) begin
      rate_sel = q1;
      mult_sel = MULT_X2;
    end else if (q2 <= tgt_ext) begin
      rate_sel = q2;
      mult_sel = MULT_X4;
    end else begin
      rate_ok = 1'b0;
    end
  end

  assign err      = tgt - rate_sel[TGT_W-1:0];
  assign better   = rate_ok && (err < {{(TGT_W-ERR_W){1'b0}}, best_err});
  assign best_div = div_rom(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_clock_hz <= BUS_CLOCK_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      bus_clock_hz <= pwdata[CLK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      priority if ((state == S_FINISH) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state      <= S_DIV;
            tgt        <= target_hz;
            idx        <= '0;
            cnt        <= '0;
            quo        <= bus_clock_hz;
            rem        <= '0;
            best_err   <= ERR_START;
            best_idx   <= '0;
            best_rate  <= '0;
            best_mult  <= MULT_X1;
            best_found <= 1'b0;
          end
        end
        S_DIV: begin
          rem <= q_bit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
          quo <= {quo[CLK_W-2:0], q_bit};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST_STEP) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (better) begin
            best_err   <= err[ERR_W-1:0];
            best_idx   <= idx;
            best_rate  <= rate_sel[TGT_W-1:0];
            best_mult  <= mult_sel;
            best_found <= 1'b1;
          end
          if (idx == IDX_LAST) begin
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
            idx   <= idx + 1'b1;
            cnt   <= '0;
            quo   <= bus_clock_hz;
            rem   <= '0;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            state           <= S_IDLE;
            found           <= best_found;
            divider_index   <= best_found ? best_idx : '0;
            multiplier_code <= best_found ? best_mult : MULT_X1;
            achieved_hz     <= best_found ? best_rate : '0;
            low_timeout     <= best_found ?
                               (LTO_W'(best_div >> 1) + LTO_W'(1)) : '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DIV) && (idx == '0) && (cnt == '0))
    else $error("search did not start at the first entry after a transfer");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (divider_index == '0) && (multiplier_code == MULT_X1) &&
                              (achieved_hz == '0) && (low_timeout == '0))
    else $error("result without a divider carries nonzero fields");

  a_mult_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (multiplier_code == MULT_X1) || (multiplier_code == MULT_X2) ||
                  (multiplier_code == MULT_X4))
    else $error("illegal prescale code on the result");

  a_timeout_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (low_timeout >= LTO_W'(11)) && (low_timeout <= LTO_W'(1921)))
    else $error("low timeout outside the divider table range");

endmodule
